// ----- rtl/core/cfb_pkg.sv -----
// Shared types and constants of the circular FIFO buffer.
// Used by the channel interfaces and the top level; no dependencies.
`default_nettype none

package cfb_pkg;

  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 9;
  localparam int CAP_W    = 9;
  localparam int CAP_MAX  = 511;
  localparam int CAP_RST  = 256;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_TOO_FAR = 2'd3
  } status_t;

  localparam logic REG_CAPACITY = 1'b0;

endpackage

`default_nettype wire

// ----- rtl/core/cfb_if.sv -----
// Valid/ready channel interfaces of the circular FIFO buffer: operation
// requests in, results out. Depends on cfb_pkg.
`default_nettype none

interface cfb_in_if;
  logic                        valid;
  logic                        ready;
  logic [cfb_pkg::OP_W-1:0]    operation;
  logic [cfb_pkg::BYTE_W-1:0]  data_in;
  logic [cfb_pkg::POS_W-1:0]   position;

  modport source (output valid, output operation, output data_in, output position,
                  input ready);
  modport sink   (input valid, input operation, input data_in, input position,
                  output ready);
endinterface

interface cfb_out_if;
  logic                          valid;
  logic                          ready;
  logic [cfb_pkg::STATUS_W-1:0]  status;
  logic [cfb_pkg::BYTE_W-1:0]    data_out;
  logic [cfb_pkg::CNT_W-1:0]     count;
  logic                          is_full;
  logic                          is_empty;
  logic                          overflow;

  modport source (output valid, output status, output data_out, output count,
                  output is_full, output is_empty, output overflow, input ready);
  modport sink   (input valid, input status, input data_out, input count,
                  input is_full, input is_empty, input overflow, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/circular_fifo_buffer_unit.sv -----
// Circular FIFO buffer top level: ring control, result stage and APB register.
// Depends on cfb_pkg, cfb_in_if, cfb_out_if and cfb_ram.
//
// Usage:
//   in_ch carries one transaction per operation: add (store data_in at the
//   newest end), remove (return the oldest byte) or peek (return the byte
//   position places back from the newest). out_ch returns one transaction per
//   operation with status, data_out, count and the full, empty and sticky
//   overflow flags. The capacity register (APB, address 0) sets the ring size
//   and clears the ring; write it only while no transaction is in flight.
// Pipeline and throughput:
//   A result passes the result stage and then the output register. One
//   request per cycle is accepted while out_ch does not stall: ring pointers
//   and count update in the accept cycle, the ring memory read takes the next
//   cycle and the byte is registered with the result.
// Reset:
//   Synchronous, active low. The ring is empty, overflow is clear and the
//   capacity returns to 256 entries. Ring storage itself is not cleared.
// Stall:
//   When out_ch is not ready the result stays in the output register, one more
//   request is held in the result stage and in_ch.ready then drops.
`default_nettype none

module circular_fifo_buffer_unit #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  cfb_in_if.sink                           in_ch,
  cfb_out_if.source                        out_ch,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [cfb_pkg::APB_AW-1:0]  cfg_paddr,
  input  wire logic [cfb_pkg::APB_DW-1:0]  cfg_pwdata,
  output      logic [cfb_pkg::APB_DW-1:0]  cfg_prdata,
  output      logic                        cfg_pready
);

  localparam int RW = (DATA_WIDTH < cfb_pkg::BYTE_W) ? DATA_WIDTH : cfb_pkg::BYTE_W;
  localparam int RD = (DEPTH < cfb_pkg::CAP_MAX) ? DEPTH : cfb_pkg::CAP_MAX;
  localparam int AW = $clog2(RD);
  localparam int SW = cfb_pkg::CAP_W + 2;
  localparam logic [cfb_pkg::CAP_W-1:0] RD_CAP = cfb_pkg::CAP_W'(RD);

  typedef struct packed {
    cfb_pkg::status_t            status;
    logic                        use_ram;
    logic [cfb_pkg::CNT_W-1:0]   count;
    logic                        is_full;
    logic                        is_empty;
    logic                        overflow;
  } res_t;

  logic [cfb_pkg::CAP_W-1:0] capacity_r, capacity_nxt;
  logic [cfb_pkg::CAP_W-1:0] cap_eff_r, cap_eff_nxt;
  logic [AW-1:0]             wr_idx_r, wr_idx_nxt;
  logic [AW-1:0]             rd_idx_r, rd_idx_nxt;
  logic [cfb_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      s1_valid_r;
  res_t                      s1_r, s1_nxt;
  logic                      out_valid_r;
  res_t                      out_r;
  logic [cfb_pkg::BYTE_W-1:0] out_data_r;

  logic             accept, s1_move, cfg_wr;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [RW-1:0]    ram_rdata;
  logic [SW-1:0]    peek_diff;
  logic [cfb_pkg::CAP_W-1:0] cap_in;

  assign s1_move   = s1_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready = ~s1_valid_r | s1_move;
  assign accept    = in_ch.valid & in_ch.ready;
  assign cfg_wr    = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                     & (cfg_paddr[2] == cfb_pkg::REG_CAPACITY);
  assign cfg_pready = 1'b1;
  assign cap_in    = cfg_pwdata[cfb_pkg::CAP_W-1:0];

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == cfb_pkg::REG_CAPACITY) begin
      cfg_prdata = cfb_pkg::APB_DW'(capacity_r);
    end
  end

  assign peek_diff = SW'(wr_idx_r) - SW'(1) - SW'(in_ch.position);

  always_comb begin
    capacity_nxt = capacity_r;
    cap_eff_nxt  = cap_eff_r;
    wr_idx_nxt   = wr_idx_r;
    rd_idx_nxt   = rd_idx_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = rd_idx_r;
    s1_nxt       = s1_r;

    if (cfg_wr) begin
      capacity_nxt = cap_in;
      if (cap_in == '0) begin
        cap_eff_nxt = cfb_pkg::CAP_W'(1);
      end else if (cap_in > RD_CAP) begin
        cap_eff_nxt = RD_CAP;
      end else begin
        cap_eff_nxt = cap_in;
      end
      wr_idx_nxt = '0;
      rd_idx_nxt = '0;
      count_nxt  = '0;
      ovf_nxt    = 1'b0;
    end else if (accept) begin
      s1_nxt.status  = cfb_pkg::ST_OK;
      s1_nxt.use_ram = 1'b0;
      unique case (cfb_pkg::op_t'(in_ch.operation))
        cfb_pkg::OP_ADD: begin
          if (count_r >= cap_eff_r) begin
            ovf_nxt       = 1'b1;
            s1_nxt.status = cfb_pkg::ST_FULL;
          end else begin
            ram_we = 1'b1;
            if ((SW'(wr_idx_r) + SW'(1)) >= SW'(cap_eff_r)) begin
              wr_idx_nxt = '0;
            end else begin
              wr_idx_nxt = wr_idx_r + AW'(1);
            end
            count_nxt = count_r + cfb_pkg::CNT_W'(1);
          end
        end
        cfb_pkg::OP_REMOVE: begin
          if (count_r == '0) begin
            s1_nxt.status = cfb_pkg::ST_EMPTY;
          end else begin
            ram_re         = 1'b1;
            ram_raddr      = rd_idx_r;
            s1_nxt.use_ram = 1'b1;
            if ((SW'(rd_idx_r) + SW'(1)) >= SW'(cap_eff_r)) begin
              rd_idx_nxt = '0;
            end else begin
              rd_idx_nxt = rd_idx_r + AW'(1);
            end
            count_nxt = count_r - cfb_pkg::CNT_W'(1);
          end
        end
        cfb_pkg::OP_PEEK: begin
          if (cfb_pkg::CNT_W'(in_ch.position) >= count_r) begin
            s1_nxt.status = cfb_pkg::ST_TOO_FAR;
          end else begin
            ram_re         = 1'b1;
            s1_nxt.use_ram = 1'b1;
            if (peek_diff[SW-1]) begin
              ram_raddr = AW'(peek_diff + SW'(cap_eff_r));
            end else begin
              ram_raddr = AW'(peek_diff);
            end
          end
        end
        default: begin
        end
      endcase
      s1_nxt.count    = count_nxt;
      s1_nxt.is_full  = (count_nxt == cap_eff_r);
      s1_nxt.is_empty = (count_nxt == '0);
      s1_nxt.overflow = ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= cfb_pkg::CAP_W'(cfb_pkg::CAP_RST);
      cap_eff_r   <= (cfb_pkg::CAP_RST > RD) ? RD_CAP : cfb_pkg::CAP_W'(cfb_pkg::CAP_RST);
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      capacity_r <= capacity_nxt;
      cap_eff_r  <= cap_eff_nxt;
      wr_idx_r   <= wr_idx_nxt;
      rd_idx_r   <= rd_idx_nxt;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    if (s1_move) begin
      out_r      <= s1_r;
      out_data_r <= s1_r.use_ram ? cfb_pkg::BYTE_W'(ram_rdata) : '0;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_r.status;
  assign out_ch.data_out = out_data_r;
  assign out_ch.count    = out_r.count;
  assign out_ch.is_full  = out_r.is_full;
  assign out_ch.is_empty = out_r.is_empty;
  assign out_ch.overflow = out_r.overflow;

  cfb_ram #(
    .WIDTH (RW),
    .DEPTH (RD)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (in_ch.data_in[RW-1:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ----- rtl/core/cfb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
